### hw/rtl/spng_pkg.sv
// shared widths, codes and filter coefficients of the sine and pink noise generator
`timescale 1ns / 1ps

package spng_pkg;

  // default parameter values
  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;

  // configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int STEP_W      = 32;
  localparam int AMP_W       = 16;
  localparam int MODE_W      = 2;

  typedef logic [MODE_W-1:0]      mode_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam mode_t MODE_SILENCE = 2'd0;
  localparam mode_t MODE_SINE    = 2'd1;
  localparam mode_t MODE_WHITE   = 2'd2;
  localparam mode_t MODE_PINK    = 2'd3;

  localparam cfg_index_t REG_WAVEFORM_MODE = 8'd0;
  localparam cfg_index_t REG_PHASE_STEP    = 8'd1;
  localparam cfg_index_t REG_AMPLITUDE     = 8'd2;

  // datapath widths: Q1.22 noise and Q2.22 taps, one shared signed multiplier
  localparam int W22_W     = 23;
  localparam int TAP_W     = 24;
  localparam int SUM_W     = 28;
  localparam int COEF_W    = 17;
  localparam int PROD_W    = COEF_W + SUM_W;
  localparam int ROM_W     = 22;
  localparam int NUM_POLES = 6;
  localparam int NUM_TAPS  = 7;
  localparam int TAP_AW    = 3;

  // pi in Q2.30, for building the quarter-wave table
  localparam longint PI_Q30 = 64'sd3373259426;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Kellet filter coefficients in Q16
  localparam coef_t POLE_Q16 [NUM_POLES] = '{
    17'sd65461, 17'sd65098, 17'sd63504, 17'sd56787, 17'sd36045, -17'sd49912
  };
  localparam coef_t FEED_Q16 [NUM_POLES] = '{
    17'sd3638, 17'sd4920, 17'sd10083, 17'sd20348, 17'sd34928, -17'sd1107
  };
  localparam coef_t DIRECT_Q16 = 17'sd35140;
  localparam coef_t LAST_Q16   = 17'sd7597;
  localparam coef_t SCALE_Q16  = 17'sd7209;

endpackage

### hw/rtl/spng_in_if.sv
// input channel: white noise samples with buffer end mark
`timescale 1ns / 1ps

interface spng_in_if
  import spng_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] noise_sample;
  logic                          block_end;

  modport source (output valid, output noise_sample, output block_end, input ready);
  modport sink   (input valid, input noise_sample, input block_end, output ready);
endinterface

### hw/rtl/spng_out_if.sv
// output channel: generated audio samples with buffer end mark
`timescale 1ns / 1ps

interface spng_out_if
  import spng_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] audio_sample;
  logic                          block_end_res;

  modport source (output valid, output audio_sample, output block_end_res, input ready);
  modport sink   (input valid, input audio_sample, input block_end_res, output ready);
endinterface

### hw/rtl/spng_cfg_if.sv
// configuration write channel
`timescale 1ns / 1ps

interface spng_cfg_if
  import spng_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/spng_sine_rom.sv
// quarter-wave sine table, built at elaboration, registered read
`timescale 1ns / 1ps

module spng_sine_rom
  import spng_pkg::*;
#(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic [SINE_TABLE_BITS-1:0] addr,
  output logic [ROM_W-1:0]           data
);

  localparam int TabLen = 1 << SINE_TABLE_BITS;

  typedef logic [ROM_W-1:0] quarter_t [TabLen];

  // quotient truncated towards zero, by shift and subtract on the magnitude
  function automatic longint div_trunc(input longint num, input longint den);
    longint mag;
    longint rem;
    longint quo;
    logic   neg;
    neg = (num < 0);
    mag = neg ? -num : num;
    rem = 0;
    quo = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((mag >>> b) & longint'(1));
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | longint'(1);
      end
    end
    return neg ? -quo : quo;
  endfunction

  // midpoint samples of the first quadrant, Taylor series in Q30
  function automatic quarter_t build_quarter();
    quarter_t q;
    longint   x;
    longint   term;
    longint   sum;
    longint   r;
    for (int k = 0; k < TabLen; k++) begin
      x    = (longint'(2 * k + 1) * PI_Q30) >>> (SINE_TABLE_BITS + 2);
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
        term = (term * x) >>> 30;
        term = (term * x) >>> 30;
        term = -div_trunc(term, longint'((2 * n) * (2 * n + 1)));
        sum  = sum + term;
      end
      r = (sum + 128) >>> 8;
      if (r < 0) begin
        r = 0;
      end else if (r > (longint'(1) <<< ROM_W) - 1) begin
        r = (longint'(1) <<< ROM_W) - 1;
      end
      q[k] = r[ROM_W-1:0];
    end
    return q;
  endfunction

  localparam quarter_t QUARTER = build_quarter();

  always_ff @(posedge clk) begin
    data <= QUARTER[addr];
  end

endmodule

### hw/rtl/sine_and_pink_noise_generator.sv
// top level: sequencer, tap memory and shared multiplier of the sine and pink noise generator
`timescale 1ns / 1ps

// One noise sample in, one audio sample out. Silence and white noise go straight to the
// gain multiply, sine does a table read and then the gain multiply, and pink noise first
// runs the filter: the six filter taps are read, updated and written back through a
// 7-entry tap memory, one tap at a time, and every product goes through one shared
// registered multiplier. The block takes the next sample as soon as the finished one sits
// in the output register, so a slow consumer costs nothing until a second result is ready.
// Reset clears the taps at once through per-entry valid bits; there is no clearing pass.
module sine_and_pink_noise_generator
  import spng_pkg::*;
#(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  spng_in_if.sink    noise_in,
  spng_out_if.source audio_out,
  spng_cfg_if.sink   cfg
);

  localparam int StepW    = (PHASE_BITS < STEP_W) ? PHASE_BITS : STEP_W;
  localparam int NzW      = SAMPLE_BITS + 23;
  localparam int OutShift = 39 - SAMPLE_BITS;

  localparam logic signed [PROD_W:0] OUT_ROUND = (PROD_W+1)'(longint'(1) <<< (OutShift - 1));
  localparam logic signed [PROD_W:0] OUT_MAX =
    (PROD_W+1)'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [PROD_W:0] OUT_MIN = -OUT_MAX - (PROD_W+1)'(1);

  localparam logic signed [PROD_W-15:0] TAP_MAX = (PROD_W-14)'((1 <<< (TAP_W - 1)) - 1);
  localparam logic signed [PROD_W-15:0] TAP_MIN = -TAP_MAX - (PROD_W-14)'(1);

  localparam logic [TAP_AW-1:0] LAST_POLE = TAP_AW'(NUM_POLES - 1);
  localparam logic [TAP_AW-1:0] LAST_TAP  = TAP_AW'(NUM_TAPS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SINE  = 4'd1;
  localparam logic [3:0] S_GAIN  = 4'd2;
  localparam logic [3:0] S_RES   = 4'd3;
  localparam logic [3:0] S_TAP_A = 4'd4;
  localparam logic [3:0] S_TAP_B = 4'd5;
  localparam logic [3:0] S_TAP_C = 4'd6;
  localparam logic [3:0] S_LAST  = 4'd7;
  localparam logic [3:0] S_SCALE = 4'd8;
  localparam logic [3:0] S_PINK  = 4'd9;

  // round half up by 2^16, wide enough for any product plus one addend
  function automatic logic signed [PROD_W-15:0] rnd16(input logic signed [PROD_W:0] v);
    return (PROD_W-14)'((v + (PROD_W+1)'(32768)) >>> 16);
  endfunction

  function automatic logic signed [TAP_W-1:0] sat_tap(input logic signed [PROD_W-15:0] v);
    logic signed [PROD_W-15:0] c;
    c = v;
    if (v > TAP_MAX) begin
      c = TAP_MAX;
    end else if (v < TAP_MIN) begin
      c = TAP_MIN;
    end
    return c[TAP_W-1:0];
  endfunction

  // configuration
  mode_t              mode;
  logic [STEP_W-1:0]  phase_step;
  logic [AMP_W-1:0]   amplitude;

  // sequencer state and datapath registers
  logic [3:0]               state;
  logic [PHASE_BITS-1:0]    phase;
  logic signed [W22_W-1:0]  w22;
  logic                     blk;
  logic                     sine_neg;
  logic [TAP_AW-1:0]        tap_idx;
  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  s22;

  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_blk;

  // tap memory, seven Q2.22 taps
  logic signed [TAP_W-1:0] tap_mem [NUM_TAPS];
  logic [NUM_TAPS-1:0]     tap_valid;
  logic signed [TAP_W-1:0] tap_rd_q;
  logic                    tap_rd_vld;
  logic signed [TAP_W-1:0] tap_rd;
  logic [TAP_AW-1:0]       rd_addr;
  logic                    tap_we;
  logic [TAP_AW-1:0]       wr_addr;
  logic signed [TAP_W-1:0] wr_data;

  // shared multiplier operands
  logic                    mul_en;
  logic signed [COEF_W-1:0] mul_a;
  logic signed [SUM_W-1:0]  mul_b;

  logic                          in_xfer;
  logic signed [NzW-1:0]         nz_wide;
  logic signed [W22_W-1:0]       w22_in;
  logic [PHASE_BITS-1:0]         step_ext;
  logic [SINE_TABLE_BITS-1:0]    rom_addr;
  logic [ROM_W-1:0]              rom_data;
  logic signed [SUM_W-1:0]       sine_val;
  logic [TAP_AW-1:0]             tap_idx_inc;
  logic signed [TAP_W-1:0]       tap_new;
  logic signed [PROD_W:0]        res_wide;
  logic signed [PROD_W:0]        res_sat;

  assign noise_in.ready = (state == S_IDLE);
  assign cfg.ready      = 1'b1;
  assign in_xfer        = noise_in.valid && noise_in.ready;

  assign audio_out.valid         = out_valid;
  assign audio_out.audio_sample  = out_sample;
  assign audio_out.block_end_res = out_blk;

  // noise to Q1.22
  assign nz_wide  = NzW'(noise_in.noise_sample) <<< 22;
  assign w22_in   = W22_W'(nz_wide >>> (SAMPLE_BITS - 1));
  assign step_ext = PHASE_BITS'(phase_step[StepW-1:0]);

  // quadrant from the top two phase bits, mirrored index in odd quadrants
  assign rom_addr = phase[PHASE_BITS-3 -: SINE_TABLE_BITS] ^ {SINE_TABLE_BITS{phase[PHASE_BITS-2]}};
  assign sine_val = sine_neg ? -SUM_W'(rom_data) : SUM_W'(rom_data);

  spng_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk (clk),
    .addr(rom_addr),
    .data(rom_data)
  );

  assign tap_idx_inc = tap_idx + TAP_AW'(1);
  assign tap_rd      = tap_rd_vld ? tap_rd_q : '0;
  assign tap_new     = sat_tap(rnd16((PROD_W+1)'(acc) + (PROD_W+1)'(prod)));

  // output rounding and saturation
  assign res_wide = ((PROD_W+1)'(prod) + OUT_ROUND) >>> OutShift;
  always_comb begin
    res_sat = res_wide;
    if (res_wide > OUT_MAX) begin
      res_sat = OUT_MAX;
    end else if (res_wide < OUT_MIN) begin
      res_sat = OUT_MIN;
    end
  end

  // operand selection and tap memory access per step
  always_comb begin
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    rd_addr = tap_idx;
    tap_we  = 1'b0;
    wr_addr = tap_idx;
    wr_data = tap_new;
    unique case (state)
      S_TAP_A: begin
        mul_en  = 1'b1;
        mul_a   = FEED_Q16[0];
        mul_b   = SUM_W'(w22);
        rd_addr = '0;
      end
      S_TAP_B: begin
        mul_en = 1'b1;
        mul_a  = POLE_Q16[tap_idx];
        mul_b  = SUM_W'(tap_rd);
      end
      S_TAP_C: begin
        // write back tap i while reading tap i+1
        tap_we = 1'b1;
        mul_en = 1'b1;
        mul_b  = SUM_W'(w22);
        if (tap_idx == LAST_POLE) begin
          mul_a   = DIRECT_Q16;
          rd_addr = LAST_TAP;
        end else begin
          mul_a   = FEED_Q16[tap_idx_inc];
          rd_addr = tap_idx_inc;
        end
      end
      S_LAST: begin
        mul_en = 1'b1;
        mul_a  = LAST_Q16;
        mul_b  = SUM_W'(w22);
      end
      S_SCALE: begin
        tap_we  = 1'b1;
        wr_addr = LAST_TAP;
        wr_data = sat_tap(rnd16((PROD_W+1)'(prod)));
        mul_en  = 1'b1;
        mul_a   = SCALE_Q16;
        mul_b   = sum;
      end
      S_GAIN: begin
        mul_en = 1'b1;
        mul_a  = COEF_W'({1'b0, amplitude});
        mul_b  = s22;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PROD_W'(mul_a * mul_b);
    end
    if (tap_we) begin
      tap_mem[wr_addr] <= wr_data;
    end
    tap_rd_q <= tap_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_valid  <= '0;
      tap_rd_vld <= 1'b0;
    end else begin
      if (tap_we) begin
        tap_valid[wr_addr] <= 1'b1;
      end
      tap_rd_vld <= tap_valid[rd_addr];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_SILENCE;
      phase_step <= '0;
      amplitude  <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_WAVEFORM_MODE: mode       <= cfg.data[MODE_W-1:0];
        REG_PHASE_STEP:    phase_step <= cfg.data[STEP_W-1:0];
        REG_AMPLITUDE:     amplitude  <= cfg.data[AMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      out_valid <= 1'b0;
      tap_idx   <= '0;
    end else begin
      // the result step reloads the output register itself
      if (out_valid && audio_out.ready && state != S_RES) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            w22      <= w22_in;
            blk      <= noise_in.block_end;
            sine_neg <= phase[PHASE_BITS-1];
            tap_idx  <= '0;
            sum      <= '0;
            unique case (mode)
              MODE_SINE: begin
                phase <= phase + step_ext;
                state <= S_SINE;
              end
              MODE_WHITE: begin
                s22   <= SUM_W'(w22_in);
                state <= S_GAIN;
              end
              MODE_PINK: begin
                state <= S_TAP_A;
              end
              default: begin
                s22   <= '0;
                state <= S_GAIN;
              end
            endcase
          end
        end
        S_SINE: begin
          s22   <= sine_val;
          state <= S_GAIN;
        end
        S_TAP_A: begin
          state <= S_TAP_B;
        end
        S_TAP_B: begin
          acc   <= prod;
          state <= S_TAP_C;
        end
        S_TAP_C: begin
          sum <= sum + SUM_W'(tap_new);
          if (tap_idx == LAST_POLE) begin
            state <= S_LAST;
          end else begin
            tap_idx <= tap_idx_inc;
            state   <= S_TAP_B;
          end
        end
        S_LAST: begin
          // old last tap plus the rounded direct term
          sum   <= sum + SUM_W'(tap_rd) + SUM_W'(rnd16((PROD_W+1)'(prod)));
          state <= S_SCALE;
        end
        S_SCALE: begin
          state <= S_PINK;
        end
        S_PINK: begin
          s22   <= SUM_W'(rnd16((PROD_W+1)'(prod)));
          state <= S_GAIN;
        end
        S_GAIN: begin
          state <= S_RES;
        end
        S_RES: begin
          if (!out_valid || audio_out.ready) begin
            out_sample <= res_sat[SAMPLE_BITS-1:0];
            out_blk    <= blk;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // tap memory is only written during the pink filter sequence
  a_tap_write_pink : assert property (@(posedge clk) disable iff (rst)
    tap_we |-> (state == S_TAP_C || state == S_SCALE))
    else $error("tap memory written outside pink filter sequence");

  // phase moves only after a sample taken in sine mode
  a_phase_sine_only : assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(phase)) |-> $past(in_xfer && mode == MODE_SINE))
    else $error("phase advanced without a sine sample");

  // a new result appears only from the result step
  a_result_from_res : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RES))
    else $error("output loaded outside result step");

  // pole index stays inside the six filter stages
  a_tap_idx_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_TAP_B || state == S_TAP_C) |-> (tap_idx <= LAST_POLE))
    else $error("tap index beyond last pole");

endmodule
